@@ src/itp_pkg.sv @@
package itp_pkg;

  // Results one step may give, at most
  localparam int MAX_RESULTS = 16;
  localparam int NW          = $clog2(MAX_RESULTS + 1);

  // Stored operator codes
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_POW = 3'd4;

  // Operator characters
  localparam logic [7:0] CH_ADD = 8'h2B;
  localparam logic [7:0] CH_SUB = 8'h2D;
  localparam logic [7:0] CH_MUL = 8'h2A;
  localparam logic [7:0] CH_DIV = 8'h2F;
  localparam logic [7:0] CH_POW = 8'h24;

  // Result status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  // Channel payloads
  typedef struct packed {
    logic       cmd;
    logic [7:0] in_char;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Which result the datapath builds
  typedef enum logic [2:0] {
    EM_LETTER,
    EM_POP,
    EM_OVF,
    EM_BAD,
    EM_END
  } emit_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;
    logic       pop;
    logic       push;
    logic       flush;
    logic       emit;
    emit_kind_t kind;
    logic       last;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_end;
    logic is_letter;
    logic is_op;
    logic empty;
    logic full;
    logic top_pops;
    logic at_limit;
    logic last_pop;
    logic out_free;
  } dp_stat_t;

  function automatic logic [1:0] op_rank(input logic [2:0] code);
    case (code)
      OP_ADD, OP_SUB: op_rank = 2'd1;
      OP_MUL, OP_DIV: op_rank = 2'd2;
      OP_POW:         op_rank = 2'd3;
      default:        op_rank = 2'd0;
    endcase
  endfunction

  function automatic logic [7:0] op_char(input logic [2:0] code);
    case (code)
      OP_ADD:  op_char = CH_ADD;
      OP_SUB:  op_char = CH_SUB;
      OP_MUL:  op_char = CH_MUL;
      OP_DIV:  op_char = CH_DIV;
      OP_POW:  op_char = CH_POW;
      default: op_char = 8'h00;
    endcase
  endfunction

  function automatic logic is_op_char(input logic [7:0] c);
    is_op_char = (c == CH_ADD) || (c == CH_SUB) || (c == CH_MUL) ||
                 (c == CH_DIV) || (c == CH_POW);
  endfunction

  function automatic logic [2:0] char_to_op(input logic [7:0] c);
    case (c)
      CH_ADD:  char_to_op = OP_ADD;
      CH_SUB:  char_to_op = OP_SUB;
      CH_MUL:  char_to_op = OP_MUL;
      CH_DIV:  char_to_op = OP_DIV;
      default: char_to_op = OP_POW;
    endcase
  endfunction

endpackage

@@ src/itp_ram.sv @@
module itp_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/itp_dpath.sv @@
module itp_dpath import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  logic            cmd_r;
  logic [7:0]      char_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;
  logic [AW-1:0]   rd_addr;
  logic [2:0]      top;
  logic [2:0]      new_op;
  logic [1:0]      rank_top, rank_new;
  logic [CW-1:0]   count_dec;

  // Captured request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= in_data.cmd;
      char_r <= in_data.in_char;
    end
  end

  // Stack depth and per-request pop count
  always_comb begin
    count_nxt = count_r;
    if (cmd.flush) begin
      count_nxt = '0;
    end else if (cmd.pop) begin
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end
    n_nxt = n_r;
    if (cmd.load) begin
      n_nxt = '0;
    end else if (cmd.pop) begin
      n_nxt = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      n_r     <= '0;
    end else begin
      count_r <= count_nxt;
      n_r     <= n_nxt;
    end
  end

  // Read address tracks the top after this cycle's update
  assign count_dec = count_nxt - 1'b1;
  assign rd_addr   = (count_nxt == '0) ? '0 : count_dec[AW-1:0];
  assign new_op    = char_to_op(char_r);

  itp_ram #(
    .WIDTH (3),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (count_r[AW-1:0]),
    .wdata (new_op),
    .raddr (rd_addr),
    .rdata (top)
  );

  // Status toward the controller
  assign rank_top = op_rank(top);
  assign rank_new = op_rank(new_op);

  always_comb begin
    stat.is_end    = cmd_r;
    stat.is_letter = (char_r >= 8'h41 && char_r <= 8'h5A) ||
                     (char_r >= 8'h61 && char_r <= 8'h7A);
    stat.is_op     = is_op_char(char_r);
    stat.empty     = (count_r == '0);
    stat.full      = (count_r == CW'(STACK_DEPTH));
    stat.top_pops  = (rank_top > rank_new) ||
                     ((rank_top == rank_new) && (rank_new != 2'd3));
    stat.at_limit  = (n_r == NW'(MAX_RESULTS));
    stat.last_pop  = (count_r == CW'(1)) || (n_r == NW'(MAX_RESULTS - 1));
    stat.out_free  = !out_valid_r || !out_stall;
  end

  // Result register
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      case (cmd.kind)
        EM_LETTER: out_nxt = '{out_char: char_r, has_char: 1'b1, status: ST_OK, last: 1'b0};
        EM_POP:    out_nxt = '{out_char: op_char(top), has_char: 1'b1, status: ST_OK,
                               last: cmd.last};
        EM_OVF:    out_nxt = '{out_char: 8'h00, has_char: 1'b0, status: ST_OVF, last: 1'b0};
        EM_BAD:    out_nxt = '{out_char: 8'h00, has_char: 1'b0, status: ST_BAD, last: 1'b0};
        EM_END:    out_nxt = '{out_char: 8'h00, has_char: 1'b0, status: ST_OK, last: 1'b1};
        default:   out_nxt = '{out_char: 8'h00, has_char: 1'b0, status: ST_BAD, last: 1'b0};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Stack depth stays in range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count out of range");

  // No push onto a full stack, no pop from an empty one
  a_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && stat.full) && !(cmd.pop && stat.empty))
    else $error("stack over or underflow");

  // A result is never written over one still waiting
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result overwritten");

endmodule

@@ src/itp_ctrl.sv @@
module itp_ctrl import itp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EVAL = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  // Sequencing: accept, then one result or stack step per cycle unless the result is stalled
  always_comb begin
    state_nxt = state_r;
    cmd       = '{load: 1'b0, pop: 1'b0, push: 1'b0, flush: 1'b0, emit: 1'b0,
                  kind: EM_BAD, last: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (stat.is_end) begin
          // flush the stack, top first
          if (stat.out_free) begin
            cmd.emit = 1'b1;
            if (stat.empty) begin
              cmd.kind  = EM_END;
              state_nxt = S_IDLE;
            end else begin
              cmd.kind = EM_POP;
              cmd.pop  = 1'b1;
              cmd.last = stat.last_pop;
              if (stat.last_pop) begin
                cmd.flush = 1'b1;
                state_nxt = S_IDLE;
              end
            end
          end
        end else if (stat.is_letter) begin
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = EM_LETTER;
            state_nxt = S_IDLE;
          end
        end else if (stat.is_op) begin
          if (!stat.empty && !stat.at_limit && stat.top_pops) begin
            if (stat.out_free) begin
              cmd.emit = 1'b1;
              cmd.kind = EM_POP;
              cmd.pop  = 1'b1;
            end
          end else if (stat.full) begin
            if (stat.out_free) begin
              cmd.emit  = 1'b1;
              cmd.kind  = EM_OVF;
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          if (stat.out_free) begin
            cmd.emit  = 1'b1;
            cmd.kind  = EM_BAD;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Every accepted request moves on to evaluation, where it leaves through at least one stack or result step
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_EVAL)
    else $error("request not evaluated");

  // Stack changes and result writes happen only while evaluating
  a_eval_only: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.push || cmd.emit) |-> state_r == S_EVAL)
    else $error("datapath command outside evaluation");

endmodule

@@ src/infix_to_postfix_converter.sv @@
// Sequence: an accepted request is captured into the request register and the controller
//   enters evaluation, which pushes an operator or loads a letter, invalid character,
//   overflow or empty end result into the result register; each pop loads its operator.
//   A new request is taken only once evaluation of the last one ends (in_stall is high
//   until then). The single stack read port gives one pop a cycle while not stalled.
// Reset (rst_n, synchronous): clears controller state, stack count and result
//   valid; stack memory contents are not cleared and need no clearing pass.
module infix_to_postfix_converter import itp_pkg::*; #(
  parameter int STACK_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  itp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

@@ bench/tb_infix_to_postfix_converter.sv @@
`timescale 1ns / 100ps

module tb_infix_to_postfix_converter;
  import itp_pkg::*;

  localparam int         DEPTH        = 16;
  localparam int         RANDOM_REQS  = 165;
  localparam int         TAIL_CYCLES  = MAX_RESULTS + 8;
  localparam int         ERR_SHOWN    = 10;
  localparam logic [1:0] RANK_POW     = 2'd3;

  // Token classes for malformed sequences
  typedef enum int {
    TK_LETTER,
    TK_OPERATOR,
    TK_NOISE,
    TK_END
  } token_kind_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Expected postfix output, oldest first
  out_item_t  postfix_queue[$];

  // Shadow operator stack
  logic [2:0] op_stack [DEPTH];
  int         op_depth;

  int reqs_sent       = 0;
  int exprs_sent      = 0;
  int results_checked = 0;
  int errors          = 0;
  int pops_seen       = 0;
  int ovf_seen        = 0;
  int bad_seen        = 0;
  int max_depth       = 0;

  bit        tx_quiet   = 1'b0;
  int        stall_left = 0;
  bit        stall_on   = 1'b0;
  int        stall_pick;
  out_item_t want_item;

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2000000;
    $display("tb_infix_to_postfix_converter failed");
    $finish;
  end

  function automatic out_item_t make_result(input logic [7:0] ch, input logic has,
                                            input logic [1:0] st, input logic fin);
    out_item_t r;
    r.out_char = ch;
    r.has_char = has;
    r.status   = st;
    r.last     = fin;
    return r;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit decode_op(input logic [7:0] c, output logic [2:0] code);
    code = OP_ADD;
    decode_op = 1'b1;
    case (c)
      CH_ADD:  code = OP_ADD;
      CH_SUB:  code = OP_SUB;
      CH_MUL:  code = OP_MUL;
      CH_DIV:  code = OP_DIV;
      CH_POW:  code = OP_POW;
      default: decode_op = 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] rank_of(input logic [2:0] code);
    if (code == OP_POW)
      return RANK_POW;
    if (code == OP_MUL || code == OP_DIV)
      return 2'd2;
    return 2'd1;
  endfunction

  function automatic logic [7:0] char_of(input logic [2:0] code);
    case (code)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0)
      return 8'(8'h41 + $urandom_range(0, 25));
    return 8'(8'h61 + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  function automatic logic [7:0] rand_noise();
    logic [7:0] c;
    logic [2:0] code;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (is_letter(c) || decode_op(c, code));
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (tx_quiet)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Shunting-yard step: update the shadow stack, queue what should come out
  task automatic predict_postfix(input in_item_t req);
    logic [2:0] code;
    logic [2:0] top;
    logic [1:0] prio;
    logic       fin;
    int         n;
    n = 0;
    if (req.cmd) begin
      if (op_depth == 0) begin
        postfix_queue.push_back(make_result(8'h00, 1'b0, ST_OK, 1'b1));
      end else begin
        while (op_depth > 0 && n < MAX_RESULTS) begin
          fin = (op_depth == 1) || (n == MAX_RESULTS - 1);
          op_depth--;
          postfix_queue.push_back(make_result(char_of(op_stack[op_depth]), 1'b1, ST_OK, fin));
          n++;
        end
        op_depth = 0;
      end
    end else if (is_letter(req.in_char)) begin
      postfix_queue.push_back(make_result(req.in_char, 1'b1, ST_OK, 1'b0));
    end else if (!decode_op(req.in_char, code)) begin
      postfix_queue.push_back(make_result(8'h00, 1'b0, ST_BAD, 1'b0));
      bad_seen++;
    end else begin
      prio = rank_of(code);
      // pop higher ranks, and equal ranks for left-associative operators
      while (op_depth > 0 && n < MAX_RESULTS) begin
        top = op_stack[op_depth - 1];
        if (rank_of(top) > prio || (rank_of(top) == prio && prio != RANK_POW)) begin
          op_depth--;
          postfix_queue.push_back(make_result(char_of(top), 1'b1, ST_OK, 1'b0));
          n++;
        end else begin
          break;
        end
      end
      if (op_depth >= DEPTH) begin
        postfix_queue.push_back(make_result(8'h00, 1'b0, ST_OVF, 1'b0));
        ovf_seen++;
      end else begin
        op_stack[op_depth] = code;
        op_depth++;
        if (op_depth > max_depth)
          max_depth = op_depth;
      end
    end
    pops_seen += n;
  endtask

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= ERR_SHOWN)
      $display("[%0t] %s", $time, msg);
  endtask

  // Drive one request and hold it until taken
  task automatic send_request(input in_item_t req);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_postfix(req);
    reqs_sent++;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    in_item_t req;
    req.cmd     = 1'b0;
    req.in_char = c;
    send_request(req);
  endtask

  task automatic send_end(input logic [7:0] junk);
    in_item_t req;
    req.cmd     = 1'b1;
    req.in_char = junk;
    send_request(req);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i]);
  endtask

  // Stop sending until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (postfix_queue.size() != 0);
  endtask

  // Letter/operator chain, rare noise, end; heavy mode favors '$' for depth
  task automatic send_expression(input int operands, input bit pow_heavy);
    for (int i = 0; i < operands; i++) begin
      send_char(rand_letter());
      if ($urandom_range(0, 19) == 0)
        send_char(rand_noise());
      if (i < operands - 1) begin
        if (pow_heavy && $urandom_range(0, 5) != 0)
          send_char(CH_POW);
        else
          send_char(rand_op());
      end
    end
    send_end(8'($urandom_range(0, 255)));
    exprs_sent++;
  endtask

  task automatic send_broken_sequence(input int count);
    token_kind_t kind;
    repeat (count) begin
      kind = token_kind_t'($urandom_range(0, 3));
      case (kind)
        TK_LETTER:   send_char(rand_letter());
        TK_OPERATOR: send_char(rand_op());
        TK_NOISE:    send_char(rand_noise());
        default:     send_end(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic test_letters_and_operators();
    // all five operators, letter range edges, right-assoc '$' chain
    tx_quiet = 1'b1;
    send_text("A+z*a$Z$b");
    tx_quiet = 1'b0;
    send_text("-c/d");
    send_end(8'h00);
    send_end(8'hFF);
    wait_drained();
  endtask

  task automatic test_invalid_characters();
    // neighbors of the letter ranges and the byte extremes
    send_char(8'h00);
    send_char(8'h40);
    send_char(8'h7B);
    send_char(8'hFF);
    send_end(8'h5A);
    wait_drained();
  endtask

  task automatic test_stack_overflow();
    // fill the stack with '$', overflow it, then pop everything with '+'
    send_char(8'h71);
    repeat (DEPTH + 1) send_char(CH_POW);
    send_char(CH_ADD);
    wait_drained();
    send_end(8'($urandom_range(0, 255)));
    wait_drained();
  endtask

  task automatic test_random_expressions();
    int target;
    int shape;
    target = reqs_sent + RANDOM_REQS;
    while (reqs_sent < target) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      shape = $urandom_range(0, 99);
      if (shape < 65)
        send_expression($urandom_range(1, 7), 1'b0);
      else if (shape < 77)
        send_expression($urandom_range(12, 20), 1'b1);
      else if (shape < 92)
        send_broken_sequence($urandom_range(1, 8));
      else
        repeat ($urandom_range(1, 4)) send_char(rand_noise());
      if ($urandom_range(0, 15) == 0)
        wait_drained();
    end
    tx_quiet = 1'b0;
    send_end(8'($urandom_range(0, 255)));
  endtask

  // Output back-pressure: bursts of stall and stretches without
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 35) begin
        stall_on   = 1'b0;
        stall_left = $urandom_range(1, 8);
      end else if (stall_pick < 50) begin
        stall_on   = 1'b0;
        stall_left = $urandom_range(30, 80);
      end else if (stall_pick < 88) begin
        stall_on   = 1'b1;
        stall_left = $urandom_range(1, 3);
      end else begin
        stall_on   = 1'b1;
        stall_left = $urandom_range(10, 40);
      end
    end else begin
      stall_left = stall_left - 1;
    end
    out_stall <= stall_on;
  end

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (postfix_queue.size() == 0) begin
        flag_error($sformatf("unexpected result: char %h has %b status %0d last %b",
                             out_data.out_char, out_data.has_char, out_data.status,
                             out_data.last));
      end else begin
        want_item = postfix_queue.pop_front();
        results_checked++;
        if (out_data.out_char !== want_item.out_char ||
            out_data.has_char !== want_item.has_char ||
            out_data.status   !== want_item.status   ||
            out_data.last     !== want_item.last) begin
          flag_error($sformatf({"mismatch: expected char %h has %b status %0d last %b,",
                                " got char %h has %b status %0d last %b"},
                               want_item.out_char, want_item.has_char, want_item.status,
                               want_item.last, out_data.out_char, out_data.has_char,
                               out_data.status, out_data.last));
        end
      end
    end
  end

  initial begin
    op_depth = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_letters_and_operators();
    test_invalid_characters();
    test_stack_overflow();
    test_random_expressions();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d generated expressions), checked %0d results.",
             reqs_sent, exprs_sent, results_checked);
    $display("Operator pops %0d, overflows %0d, invalid chars %0d, deepest stack %0d.",
             pops_seen, ovf_seen, bad_seen, max_depth);
    if (errors == 0) begin
      $display("tb_infix_to_postfix_converter passed");
    end else begin
      $display("%0d errors", errors);
      $display("tb_infix_to_postfix_converter failed");
    end
    $finish;
  end

endmodule
